// ----- rtl/cigar_normalizing_builder_macros.svh -----
// assertion macros for the cigar normalizing builder
`ifndef CIGAR_NORMALIZING_BUILDER_MACROS_SVH
`define CIGAR_NORMALIZING_BUILDER_MACROS_SVH

// same-cycle implication
`define CNB_ASSERT_IMPL(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define CNB_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- rtl/cnb_pkg.sv -----
// types, codes and helper functions for the cigar normalizing builder
package cnb_pkg;

	localparam logic [3:0] OP_I    = 4'd1;
	localparam logic [3:0] OP_D    = 4'd2;
	localparam logic [3:0] OP_S    = 4'd4;
	localparam logic [3:0] OP_H    = 4'd5;
	localparam logic [3:0] OP_MAX  = 4'd8;
	localparam logic [3:0] OP_NONE = 4'd15;

	typedef struct packed {
		logic [27:0] len;
		logic [3:0]  op;
	} elem_t;

	typedef enum logic [2:0] {
		SEC_LEFT_HARD,
		SEC_LEFT_SOFT,
		SEC_MIDDLE,
		SEC_RIGHT_SOFT,
		SEC_RIGHT_HARD
	} sec_t;

	typedef enum logic {
		ST_RUN,
		ST_DRAIN
	} state_t;

	function automatic logic is_clip(logic [3:0] o);
		return (o == OP_S) || (o == OP_H);
	endfunction

	function automatic logic [27:0] sat28(logic [27:0] a, logic [27:0] b);
		logic [28:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[28] ? {28{1'b1}} : s[27:0];
	endfunction

	function automatic logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? {32{1'b1}} : s[31:0];
	endfunction

	function automatic sec_t adv_sec(sec_t s, logic [3:0] o);
		sec_t r;
		r = s;
		if (o == OP_H) begin
			if (s == SEC_LEFT_SOFT || s == SEC_MIDDLE || s == SEC_RIGHT_SOFT) r = SEC_RIGHT_HARD;
		end else if (o == OP_S) begin
			if (s == SEC_LEFT_HARD) r = SEC_LEFT_SOFT;
			else if (s == SEC_MIDDLE) r = SEC_RIGHT_SOFT;
		end else if (s == SEC_LEFT_HARD || s == SEC_LEFT_SOFT) begin
			r = SEC_MIDDLE;
		end
		return r;
	endfunction

endpackage

// ----- rtl/cigar_normalizing_builder.sv -----
// cigar normalizing builder: element stack with merge, deletion moves and drain
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid in_stall op length final_req     | in
//  output  | out_valid out_stall out_op out_length     | out
//          | out_last empty_res leading_removed        |
//          | trailing_removed trailing_removed_at_end  |
//
// one element is taken per cycle outside a drain; the top two stack entries sit
// in flops and older entries spill to a ram, one write per cycle.
// a final element starts a drain: the registered ram read comes first, then
// max(n,1) results, one per cycle unless stalled; input is stalled meanwhile.
// an output stall holds the result register and pauses the drain.
// reset returns to an empty stack; the ram needs no clearing.
`include "cigar_normalizing_builder_macros.svh"

module cigar_normalizing_builder #(
	parameter int STACK_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  op,
	input  logic [27:0] length,
	input  logic        final_req,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  out_op,
	output logic [27:0] out_length,
	output logic        out_last,
	output logic        empty_res,
	output logic [31:0] leading_removed,
	output logic [31:0] trailing_removed,
	output logic [27:0] trailing_removed_at_end
);

	import cnb_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	state_t      state_q;
	logic [CW-1:0] cnt_q, idx_q;
	logic [3:0]  last_q;
	sec_t        sec_q;
	logic [31:0] lead_q, trail_q;
	elem_t       t1_q, t2_q;
	logic        rd_ok_q;

	elem_t       d_t1_q, d_t2_q;
	logic [CW-1:0] d_cnt_q, d_nout_q;
	logic [31:0] d_lead_q, d_trail_q;
	logic [27:0] d_end_q;

	logic        out_valid_q;

	logic [CW-1:0] n_cnt;
	logic [3:0]  n_last;
	sec_t        n_sec;
	elem_t       n_t1, n_t2;
	logic [31:0] n_lead, n_trail;
	logic        spill, push, dti, lead_drop, elem_ok, in_acc;

	logic        f_dti;
	logic [CW-1:0] f_nout;
	elem_t       f_t2;
	logic [27:0] f_end;

	logic [31:0] ram_rdata;
	elem_t       d_item;
	logic        d_is_last, ld;
	logic [CW-1:0] rd_idx, spill_idx;

	assign in_stall  = (state_q == ST_DRAIN);
	assign in_acc    = in_valid && !in_stall;
	assign elem_ok   = (length != '0) && (op <= OP_MAX);
	assign out_valid = out_valid_q;

	always_comb begin
		n_cnt   = cnt_q;
		n_last  = last_q;
		n_sec   = sec_q;
		n_t1    = t1_q;
		n_t2    = t2_q;
		n_lead  = lead_q;
		n_trail = trail_q;
		spill   = 1'b0;
		dti = (last_q == OP_I) && (cnt_q > CW'(1)) && (t2_q.op == OP_D);
		lead_drop = (op == OP_D) && ((last_q == OP_NONE) || is_clip(last_q) ||
			((last_q == OP_I) && ((cnt_q == CW'(1)) ||
			((cnt_q >= CW'(2)) && is_clip(t2_q.op)))));
		priority if (op == last_q) push = (cnt_q == '0);
		else if (last_q == OP_NONE) push = 1'b1;
		else if (is_clip(op)) push = !(((last_q == OP_D) && (cnt_q != '0)) || dti);
		else if ((op == OP_D) && (last_q == OP_I)) push = !dti;
		else push = 1'b1;

		if (elem_ok) begin
			if (lead_drop) begin
				n_lead = sat32(lead_q, {4'b0, length});
			end else if (!(push && (cnt_q >= CW'(STACK_DEPTH)))) begin
				n_sec = adv_sec(sec_q, op);
				priority if ((op == last_q) && (cnt_q != '0)) begin
					n_t1 = '{len: sat28(t1_q.len, length), op: op};
				end else if ((last_q != OP_NONE) && is_clip(op) && (last_q == OP_D) &&
						(cnt_q != '0)) begin
					n_trail = sat32(trail_q, {4'b0, t1_q.len});
					n_t1    = '{len: length, op: op};
					n_last  = op;
				end else if ((last_q != OP_NONE) && is_clip(op) && dti) begin
					n_trail = sat32(trail_q, {4'b0, t2_q.len});
					n_t2    = t1_q;
					n_t1    = '{len: length, op: op};
					n_last  = op;
				end else if ((op == OP_D) && (last_q == OP_I) && (cnt_q != '0) && !push) begin
					n_t2 = '{len: sat28(t2_q.len, length), op: OP_D};
				end else if ((op == OP_D) && (last_q == OP_I) && (cnt_q != '0)) begin
					n_t2  = '{len: length, op: OP_D};
					n_cnt = cnt_q + CW'(1);
					spill = (cnt_q >= CW'(2));
				end else begin
					n_t2   = t1_q;
					n_t1   = '{len: length, op: op};
					n_cnt  = cnt_q + CW'(1);
					n_last = op;
					spill  = (cnt_q >= CW'(2));
				end
			end
		end
	end

	always_comb begin
		f_dti  = (n_last == OP_I) && (n_cnt > CW'(1)) && (n_t2.op == OP_D);
		f_nout = n_cnt;
		f_t2   = n_t2;
		f_end  = '0;
		priority if ((n_last == OP_D) && (n_cnt != '0)) begin
			f_end  = n_t1.len;
			f_nout = n_cnt - CW'(1);
		end else if (f_dti) begin
			f_end  = n_t2.len;
			f_nout = n_cnt - CW'(1);
			f_t2   = n_t1;
		end else begin
			f_end = '0;
		end
	end

	always_comb begin
		d_item = elem_t'(ram_rdata);
		if (idx_q == d_cnt_q - CW'(2)) d_item = d_t2_q;
		else if (idx_q == d_cnt_q - CW'(1)) d_item = d_t1_q;
		d_is_last = (d_nout_q == '0) || (idx_q == d_nout_q - CW'(1));
		ld        = (state_q == ST_DRAIN) && rd_ok_q && (!out_valid_q || !out_stall);
		rd_idx    = ld ? idx_q + CW'(1) : idx_q;
		spill_idx = cnt_q - CW'(2);
	end

	cnb_ram #(
		.WIDTH ($bits(elem_t)),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (in_acc && spill),
		.waddr (spill_idx[AW-1:0]),
		.wdata (t2_q),
		.raddr (rd_idx[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			cnt_q       <= '0;
			last_q      <= OP_NONE;
			sec_q       <= SEC_LEFT_HARD;
			lead_q      <= '0;
			trail_q     <= '0;
			idx_q       <= '0;
			rd_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				if (final_req) begin
					state_q <= ST_DRAIN;
					cnt_q   <= '0;
					last_q  <= OP_NONE;
					sec_q   <= SEC_LEFT_HARD;
					lead_q  <= '0;
					trail_q <= '0;
				end else begin
					cnt_q   <= n_cnt;
					last_q  <= n_last;
					sec_q   <= n_sec;
					lead_q  <= n_lead;
					trail_q <= n_trail;
				end
			end
			rd_ok_q <= (state_q == ST_DRAIN) && !(ld && d_is_last);
			if (ld) begin
				if (d_is_last) begin
					state_q <= ST_RUN;
					idx_q   <= '0;
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			if (ld) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			t1_q <= n_t1;
			t2_q <= n_t2;
			if (final_req) begin
				d_t1_q    <= n_t1;
				d_t2_q    <= f_t2;
				d_cnt_q   <= n_cnt;
				d_nout_q  <= f_nout;
				d_lead_q  <= n_lead;
				d_trail_q <= n_trail;
				d_end_q   <= f_end;
			end
		end
		if (ld) begin
			out_op                  <= (d_nout_q == '0) ? 4'd0 : d_item.op;
			out_length              <= (d_nout_q == '0) ? 28'd0 : d_item.len;
			out_last                <= d_is_last;
			empty_res               <= (d_nout_q == '0);
			leading_removed         <= d_lead_q;
			trailing_removed        <= d_trail_q;
			trailing_removed_at_end <= d_end_q;
		end
	end

	`CNB_ASSERT_NEXT(a_final_starts_drain, in_acc && final_req, in_stall, "no drain after final")
	`CNB_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CW'(STACK_DEPTH), "stack count overflow")
	`CNB_ASSERT_IMPL(a_idx_bound, state_q == ST_DRAIN, idx_q <= d_nout_q, "drain index past end")
	`CNB_ASSERT_IMPL(a_empty_alone, out_valid && empty_res,
		out_last && (out_length == '0) && (out_op == '0), "empty result malformed")

endmodule

// ----- rtl/cnb_ram.sv -----
// generic single-write, single-read ram with registered read data
module cnb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ----- test/tb_cigar_normalizing_builder.sv -----
// self-checking testbench for the cigar normalizing builder: directed, stack-full and random runs
module tb_cigar_normalizing_builder;
	import cnb_pkg::*;

	localparam int DEPTH = 32;
	localparam logic [3:0] OP_M   = 4'd0;
	localparam logic [3:0] OP_N   = 4'd3;
	localparam logic [3:0] OP_P   = 4'd6;
	localparam logic [3:0] OP_EQ  = 4'd7;
	localparam logic [3:0] OP_X   = 4'd8;
	localparam logic [3:0] OP_BAD = 4'd9;
	localparam logic [27:0] LEN_MAX = 28'hFFFFFFF;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_SLACK = 80;

	typedef struct {
		logic [3:0]  op;
		logic [27:0] len;
		logic        is_last;
		logic        is_empty;
		logic [31:0] lead;
		logic [31:0] trail;
		logic [27:0] at_end;
	} cigar_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  op = '0;
	logic [27:0] length = '0;
	logic        final_req = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  out_op;
	logic [27:0] out_length;
	logic        out_last;
	logic        empty_res;
	logic [31:0] leading_removed;
	logic [31:0] trailing_removed;
	logic [27:0] trailing_removed_at_end;

	// normalized stack as the block should hold it
	elem_t       norm_stack [DEPTH];
	int          norm_count;
	logic [3:0]  prev_op;
	logic [31:0] lead_sum;
	logic [31:0] trail_sum;

	cigar_result_t pending_results [$];

	int  errors = 0;
	int  cycles = 0;
	int  items_sent = 0;
	bit  in_idle_on = 1'b1;
	bit  out_idle_on = 1'b1;
	int  stall_left = 0;

	cigar_normalizing_builder #(.STACK_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.length(length),
		.final_req(final_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_op(out_op),
		.out_length(out_length),
		.out_last(out_last),
		.empty_res(empty_res),
		.leading_removed(leading_removed),
		.trailing_removed(trailing_removed),
		.trailing_removed_at_end(trailing_removed_at_end)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("cigar_normalizing_builder regression: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	function automatic logic clip_code(input logic [3:0] o);
		return o == OP_S || o == OP_H;
	endfunction

	function automatic logic [27:0] len_add(input logic [27:0] a, input logic [27:0] b);
		logic [28:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, LEN_MAX}) ? LEN_MAX : s[27:0];
	endfunction

	function automatic logic [31:0] count_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFFFFFF : s[31:0];
	endfunction

	function automatic void clear_builder();
		norm_count = 0;
		prev_op = OP_NONE;
		lead_sum = '0;
		trail_sum = '0;
	endfunction

	task automatic normalize_add(input logic [3:0] o, input logic [27:0] l);
		int   n;
		logic ins_after_del;
		logic push;
		n = norm_count;
		if (o == OP_D) begin
			if (prev_op == OP_NONE || clip_code(prev_op)) begin
				lead_sum = count_add(lead_sum, {4'b0, l});
				return;
			end
			if (prev_op == OP_I && (n == 1 || (n >= 2 && clip_code(norm_stack[n-2].op)))) begin
				lead_sum = count_add(lead_sum, {4'b0, l});
				return;
			end
		end
		ins_after_del = prev_op == OP_I && n > 1 && norm_stack[n-2].op == OP_D;
		if (o == prev_op)
			push = (n == 0);
		else if (prev_op == OP_NONE)
			push = 1'b1;
		else if (clip_code(o))
			push = !((prev_op == OP_D && n >= 1) || ins_after_del);
		else if (o == OP_D && prev_op == OP_I)
			push = !(n > 1 && norm_stack[n-2].op == OP_D);
		else
			push = 1'b1;
		if (push && n >= DEPTH)
			return;
		if (o == prev_op && n >= 1) begin
			norm_stack[n-1].len = len_add(norm_stack[n-1].len, l);
		end else if (prev_op != OP_NONE && clip_code(o) && prev_op == OP_D && n >= 1) begin
			trail_sum = count_add(trail_sum, {4'b0, norm_stack[n-1].len});
			norm_stack[n-1] = '{len: l, op: o};
			prev_op = o;
		end else if (prev_op != OP_NONE && clip_code(o) && ins_after_del) begin
			trail_sum = count_add(trail_sum, {4'b0, norm_stack[n-2].len});
			norm_stack[n-2] = norm_stack[n-1];
			norm_stack[n-1] = '{len: l, op: o};
			prev_op = o;
		end else if (o == OP_D && prev_op == OP_I && n >= 1 && !push) begin
			norm_stack[n-2].len = len_add(norm_stack[n-2].len, l);
		end else if (o == OP_D && prev_op == OP_I && n >= 1) begin
			norm_stack[n] = norm_stack[n-1];
			norm_stack[n-1] = '{len: l, op: OP_D};
			norm_count = n + 1;
		end else begin
			norm_stack[n] = '{len: l, op: o};
			norm_count = n + 1;
			prev_op = o;
		end
	endtask

	task automatic normalize_finish();
		int            n;
		logic [27:0]   at_end;
		cigar_result_t r;
		n = norm_count;
		at_end = '0;
		if (prev_op == OP_D && n >= 1) begin
			at_end = norm_stack[n-1].len;
			n--;
		end else if (prev_op == OP_I && n > 1 && norm_stack[n-2].op == OP_D) begin
			at_end = norm_stack[n-2].len;
			norm_stack[n-2] = norm_stack[n-1];
			n--;
		end
		r.lead = lead_sum;
		r.trail = trail_sum;
		r.at_end = at_end;
		if (n == 0) begin
			r.op = '0;
			r.len = '0;
			r.is_last = 1'b1;
			r.is_empty = 1'b1;
			pending_results.push_back(r);
		end else begin
			for (int i = 0; i < n; i++) begin
				r.op = norm_stack[i].op;
				r.len = norm_stack[i].len;
				r.is_last = (i == n - 1);
				r.is_empty = 1'b0;
				pending_results.push_back(r);
			end
		end
		clear_builder();
	endtask

	task automatic send_elem(input logic [3:0] o, input logic [27:0] l, input logic f);
		int gap;
		if (in_idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		length <= l;
		final_req <= f;
		do @(posedge clk); while (in_stall);
		if (l != 0 && o <= OP_MAX)
			normalize_add(o, l);
		if (f)
			normalize_finish();
		items_sent++;
	endtask

	always @(posedge clk) begin
		if (!out_idle_on)
			stall_left = 0;
		else if (stall_left == 0 && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 6);
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cigar_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = pending_results.pop_front();
				check_field("out_op", 32'(out_op), 32'(want.op));
				check_field("out_length", 32'(out_length), 32'(want.len));
				check_field("out_last", 32'(out_last), 32'(want.is_last));
				check_field("empty_res", 32'(empty_res), 32'(want.is_empty));
				check_field("leading_removed", leading_removed, want.lead);
				check_field("trailing_removed", trailing_removed, want.trail);
				check_field("trailing_removed_at_end", 32'(trailing_removed_at_end),
					32'(want.at_end));
			end
		end
	end

	function automatic logic [27:0] rand_length();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return 28'($urandom());
			2: return LEN_MAX - 28'($urandom_range(0, 3));
			3: return 28'd1 << $urandom_range(0, 27);
			default: return 28'($urandom_range(1, 200));
		endcase
	endfunction

	function automatic logic [3:0] rand_middle_op();
		case ($urandom_range(0, 11))
			0, 1, 2: return OP_M;
			3, 4, 5: return OP_I;
			6, 7, 8: return OP_D;
			9: return ($urandom_range(0, 1) != 0) ? OP_N : OP_P;
			10: return OP_EQ;
			default: return OP_X;
		endcase
	endfunction

	task automatic send_random_run();
		logic [3:0]  ops [$];
		logic [27:0] lens [$];
		int          n_mid;
		if ($urandom_range(0, 7) == 0) begin
			// noise: any code, clips anywhere
			n_mid = $urandom_range(1, 10);
			repeat (n_mid) begin
				ops.push_back(4'($urandom_range(0, 15)));
				lens.push_back(rand_length());
			end
		end else begin
			if ($urandom_range(0, 2) == 0) begin
				ops.push_back(OP_H);
				lens.push_back(rand_length());
			end
			if ($urandom_range(0, 2) == 0) begin
				ops.push_back(OP_S);
				lens.push_back(rand_length());
			end
			n_mid = ($urandom_range(0, 14) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 10);
			repeat (n_mid) begin
				ops.push_back(rand_middle_op());
				lens.push_back(rand_length());
			end
			if ($urandom_range(0, 2) == 0) begin
				ops.push_back(OP_S);
				lens.push_back(rand_length());
			end
			if ($urandom_range(0, 2) == 0) begin
				ops.push_back(OP_H);
				lens.push_back(rand_length());
			end
		end
		if ($urandom_range(0, 5) == 0) begin
			ops.push_back(4'($urandom_range(0, 15)));
			lens.push_back('0);
		end
		foreach (ops[i])
			send_elem(ops[i], lens[i], i == ops.size() - 1);
	endtask

	task automatic test_directed_cases();
		// empty run
		send_elem(OP_M, 28'd0, 1'b1);
		// leading deletion, maximum length
		send_elem(OP_D, 28'd5, 1'b0);
		send_elem(OP_M, 28'd10, 1'b0);
		send_elem(OP_X, LEN_MAX, 1'b1);
		// leading deletions after clips and leading insertion, deletion moved, clip after it
		send_elem(OP_H, 28'd3, 1'b0);
		send_elem(OP_S, 28'd4, 1'b0);
		send_elem(OP_D, 28'd6, 1'b0);
		send_elem(OP_I, 28'd2, 1'b0);
		send_elem(OP_D, 28'd9, 1'b0);
		send_elem(OP_M, 28'd1, 1'b0);
		send_elem(OP_I, 28'd3, 1'b0);
		send_elem(OP_D, 28'd4, 1'b0);
		send_elem(OP_D, 28'd8, 1'b0);
		send_elem(OP_S, 28'd5, 1'b0);
		send_elem(OP_H, 28'd6, 1'b1);
		// merge saturation, undefined codes
		send_elem(OP_M, LEN_MAX, 1'b0);
		send_elem(OP_M, LEN_MAX, 1'b0);
		send_elem(OP_BAD, 28'd11, 1'b0);
		send_elem(OP_NONE, 28'd7, 1'b1);
		// trailing deletion at finish
		send_elem(OP_EQ, 28'd5, 1'b0);
		send_elem(OP_D, 28'd7, 1'b1);
		// deletion-insertion at finish
		send_elem(OP_P, 28'd1, 1'b0);
		send_elem(OP_N, 28'd2, 1'b0);
		send_elem(OP_I, 28'd3, 1'b0);
		send_elem(OP_D, 28'd4, 1'b1);
		// soft-clip only
		send_elem(OP_S, 28'd10, 1'b1);
		// deletion before a clip
		send_elem(OP_M, 28'd2, 1'b0);
		send_elem(OP_D, 28'd3, 1'b0);
		send_elem(OP_H, 28'd4, 1'b1);
	endtask

	task automatic test_stack_full();
		for (int i = 0; i < DEPTH + 2; i++)
			send_elem(i[0] ? OP_X : OP_M, 28'(i + 1), 1'b0);
		send_elem(OP_I, 28'd9, 1'b0);
		send_elem(OP_D, 28'd9, 1'b0);
		send_elem(OP_M, 28'd3, 1'b1);
	endtask

	task automatic test_random_runs(input int n_items);
		int stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			in_idle_on = ($urandom_range(0, 3) != 0);
			out_idle_on = ($urandom_range(0, 3) != 0);
			send_random_run();
		end
	endtask

	task automatic test_quiet_runs(input int n_items);
		int stop_at;
		stop_at = items_sent + n_items;
		in_idle_on = 1'b0;
		out_idle_on = 1'b0;
		while (items_sent < stop_at)
			send_random_run();
	endtask

	initial begin
		clear_builder();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_stack_full();
		test_random_runs(340);
		test_quiet_runs(60);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
		if (errors == 0)
			$display("cigar_normalizing_builder regression: pass");
		else
			$display("cigar_normalizing_builder regression: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cnb_pkg.sv
rtl/cnb_ram.sv
rtl/cigar_normalizing_builder.sv
test/tb_cigar_normalizing_builder.sv
